/* sv/assert_macros.svh */
// Assertion macros shared by the sorted insert table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted insert table assertion failed");
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted insert table implication failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/sit_pkg.sv */
// Package with sizes, codes and shared types of the sorted insert table.
package sit_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DUMP   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_ELEMENT   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_SRCH_CMP,
        S_DUMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic ge;
        logic eq;
    } t_cmp;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_word wdata;
        t_idx  raddr;
    } t_ram_ctl;

endpackage

/* sv/sit_ram.sv */
// Entry store: one write port and one registered read port.
module sit_ram
    import sit_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_ctl i_ctl,
    output t_word    o_rdata
);

    t_word r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        o_rdata <= r_mem[i_ctl.raddr];
    end

endmodule

/* sv/sit_cmp.sv */
// Shared signed compare unit used by insert and search steps.
module sit_cmp
    import sit_pkg::*;
(
    input  t_word i_a,
    input  t_word i_b,
    output t_cmp  o_cmp
);

    assign o_cmp.ge = (i_a >= i_b);
    assign o_cmp.eq = (i_a == i_b);

endmodule

/* sv/sorted_insert_table.sv */
// Top level of the sorted insert table: sequencer, entry store and result register.
//
// The table holds up to CAPACITY signed 32-bit values in ascending order and walks
// them one entry per cycle through a single registered read port and one compare unit;
// a dump pauses while the output register is held. A transaction is taken only while
// the sequencer is idle. An insert shifts up every stored value not smaller than the
// new one; it writes at once into an empty table and refuses a full one. A search scans
// up to the first match; a dump emits every stored value. Results pass through an output
// register, so each result also waits for the downstream side to take it. Reset clears
// the state, the count and the output valid; no clearing pass runs over the store.
`include "assert_macros.svh"
module sorted_insert_table
    import sit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  t_word       i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output t_word       o_element,
    output logic        o_last,
    output logic [4:0]  o_count
);

    t_state   r_state, n_state;
    t_cnt     r_count, n_count;
    t_cnt     r_idx, n_idx;
    t_word    r_value, n_value;
    t_status  r_pstat, n_pstat;
    logic     r_out_valid, n_out_valid;
    t_status  r_status, n_status;
    t_word    r_element, n_element;
    logic     r_last, n_last;
    logic [4:0] r_out_count;

    t_ram_ctl ram_ctl;
    t_word    rd_data;
    t_cmp     cmp;
    logic     in_acc;
    logic     slot_free;
    logic     out_load;
    logic     scan_last;

    sit_ram u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .o_rdata (rd_data)
    );

    sit_cmp u_cmp (
        .i_a   (rd_data),
        .i_b   (r_value),
        .o_cmp (cmp)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign scan_last  = ((r_idx + 1'b1) == r_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_op'(i_opcode))
                        OP_INSERT: begin
                            if (r_count >= CNT_W'(CAPACITY) || r_count == '0) begin
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_INS_CMP;
                            end
                        end
                        OP_SEARCH: n_state = (r_count == '0) ? S_EMIT : S_SRCH_CMP;
                        OP_DUMP:   n_state = (r_count == '0) ? S_EMIT : S_DUMP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_CMP: begin
                if (cmp.ge) begin
                    n_state = (r_idx == CNT_W'(1)) ? S_INS_PUT : S_INS_CMP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_INS_PUT:  n_state = S_EMIT;
            S_SRCH_CMP: n_state = (cmp.eq || scan_last) ? S_EMIT : S_SRCH_CMP;
            S_DUMP:     n_state = (slot_free && scan_last) ? S_IDLE : S_DUMP;
            S_EMIT:     n_state = slot_free ? S_IDLE : S_EMIT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_ctl.we    = 1'b0;
        ram_ctl.waddr = r_idx[IDX_W-1:0];
        ram_ctl.wdata = r_value;
        ram_ctl.raddr = r_idx[IDX_W-1:0];
        n_count       = r_count;
        n_idx         = r_idx;
        n_value       = r_value;
        n_pstat       = r_pstat;
        out_load      = 1'b0;
        n_status      = r_pstat;
        n_element     = '0;
        n_last        = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_value = i_value;
                    n_idx   = '0;
                    ram_ctl.raddr = '0;
                    case (t_op'(i_opcode))
                        OP_INSERT: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_pstat = ST_FULL;
                            end else if (r_count == '0) begin
                                ram_ctl.we    = 1'b1;
                                ram_ctl.waddr = '0;
                                ram_ctl.wdata = i_value;
                                n_count       = CNT_W'(1);
                                n_pstat       = ST_INSERTED;
                            end else begin
                                n_idx         = r_count;
                                ram_ctl.raddr = t_idx'(r_count - 1'b1);
                            end
                        end
                        OP_SEARCH, OP_DUMP: begin
                            n_pstat = ST_EMPTY;
                        end
                        default: begin
                            n_pstat = r_pstat;
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                ram_ctl.we = 1'b1;
                if (cmp.ge) begin
                    ram_ctl.wdata = rd_data;
                    n_idx         = r_idx - 1'b1;
                    ram_ctl.raddr = t_idx'(r_idx - 2'd2);
                end else begin
                    n_count = r_count + 1'b1;
                    n_pstat = ST_INSERTED;
                end
            end
            S_INS_PUT: begin
                ram_ctl.we = 1'b1;
                n_count    = r_count + 1'b1;
                n_pstat    = ST_INSERTED;
            end
            S_SRCH_CMP: begin
                if (cmp.eq) begin
                    n_pstat = ST_FOUND;
                end else if (scan_last) begin
                    n_pstat = ST_NOT_FOUND;
                end else begin
                    n_idx         = r_idx + 1'b1;
                    ram_ctl.raddr = t_idx'(r_idx + 1'b1);
                end
            end
            S_DUMP: begin
                if (slot_free) begin
                    out_load  = 1'b1;
                    n_status  = ST_ELEMENT;
                    n_element = rd_data;
                    n_last    = scan_last;
                    if (!scan_last) begin
                        n_idx         = r_idx + 1'b1;
                        ram_ctl.raddr = t_idx'(r_idx + 1'b1);
                    end
                end
            end
            S_EMIT: begin
                out_load = slot_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_value <= n_value;
        r_pstat <= n_pstat;
        if (out_load) begin
            r_status    <= n_status;
            r_element   <= n_element;
            r_last      <= n_last;
            r_out_count <= 5'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_element   = r_element;
    assign o_last      = r_last;
    assign o_count     = r_out_count;

    `ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `ASSERT_IMPL(a_count_step, i_clk, i_rst_n, $past(i_rst_n) && !$stable(r_count), r_count == $past(r_count) + 1'b1)
    `ASSERT_IMPL(a_dump_index, i_clk, i_rst_n, r_state == S_DUMP, r_idx < r_count)
    `ASSERT_IMPL(a_plain_result, i_clk, i_rst_n, r_out_valid && r_status != ST_ELEMENT, r_last && r_element == '0)

endmodule
